@@ src/kad_pkg.sv @@
// Shared types and constants of the key affinity dispatch table.
`default_nettype none
package kad_pkg;

    localparam int KEY_W      = 32;
    localparam int WORKER_W   = 4;
    localparam int HANDLE_W   = 32;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;

    localparam logic [KEY_W-1:0] KEY_RSV_LO = '0;
    localparam logic [KEY_W-1:0] KEY_RSV_HI = '1;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_BOUND      = 3'd0,
        STAT_QUEUED     = 3'd1,
        STAT_POPPED     = 3'd2,
        STAT_RELEASED   = 3'd3,
        STAT_NO_OWNER   = 3'd4,
        STAT_TABLE_FULL = 3'd5,
        STAT_ERROR      = 3'd6
    } status_t;

endpackage
`default_nettype wire

@@ src/key_affinity_dispatch_table_top.sv @@
// Key affinity dispatch table: key-to-worker binding and per-worker handle FIFOs.
// Flow: a transfer is accepted in idle, latched with its worker state read; its result
//   is then registered, after a further FIFO memory read for a pop that returns a handle.
// A new item is accepted only after the last result enters the output register, at a pace
//   set by the worker state read and write-back, a pop's FIFO read and output stalls.
// Reset: rst_n clears all bindings and FIFO counts at once; FIFO contents stay undefined.
`default_nettype none
module key_affinity_dispatch_table_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NUM_WORKERS   = 16,
    parameter int QUEUE_DEPTH   = 16,
    parameter int HANDLE_BITS   = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // order_key[31:0], caller_worker[35:32], message_handle[67:36], zero fill
    input  wire logic [kad_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  wire logic [kad_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // popped_handle[31:0], owner_worker[35:32], zero fill
    output logic [kad_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status[2:0]
    output logic [kad_pkg::STATUS_W-1:0]         m_axis_tuser
);
    import kad_pkg::*;

    localparam int TW  = $clog2(TABLE_ENTRIES);
    localparam int WW  = $clog2(NUM_WORKERS);
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int FD  = NUM_WORKERS * QUEUE_DEPTH;
    localparam int FAW = $clog2(FD);

    typedef struct packed {
        logic [HW-1:0] head;
        logic [CW-1:0] count;
    } meta_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_DATA
    } state_t;

    // binding table
    logic                bind_valid_reg [TABLE_ENTRIES];
    logic [KEY_W-1:0]    bind_key_reg   [TABLE_ENTRIES];
    logic [WW-1:0]       bind_owner_reg [TABLE_ENTRIES];

    // worker state memory and its valid bits
    meta_t               meta_mem       [NUM_WORKERS];
    logic                meta_valid_reg [NUM_WORKERS];
    meta_t               meta_rd_reg;
    logic                meta_rd_valid_reg;

    // handle FIFO memory
    logic [SW-1:0]       fifo_mem       [FD];
    logic [SW-1:0]       fifo_rd_reg;

    state_t              state_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [WORKER_W-1:0] out_owner_reg;

    // latched item
    logic                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                key_bad_reg;
    logic                worker_bad_reg;
    logic [WW-1:0]       caller_reg;
    logic [SW-1:0]       handle_reg;
    logic                hit_reg;
    logic [TW-1:0]       hit_idx_reg;
    logic [WW-1:0]       owner_reg;
    logic                free_reg;
    logic [TW-1:0]       free_idx_reg;

    logic [KEY_W-1:0]    in_key;
    logic [WORKER_W-1:0] in_caller;
    logic [HANDLE_W-1:0] in_handle;
    logic                in_accept;
    logic                hit;
    logic [TW-1:0]       hit_idx;
    logic                free;
    logic [TW-1:0]       free_idx;
    logic [WW-1:0]       hit_owner;

    assign in_key    = s_axis_tdata[31:0];
    assign in_caller = s_axis_tdata[35:32];
    assign in_handle = s_axis_tdata[67:36];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // lowest matching entry and lowest free entry
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (bind_valid_reg[i] && (bind_key_reg[i] == in_key))
            begin
                hit     = 1'b1;
                hit_idx = TW'(i);
            end
            if (!bind_valid_reg[i])
            begin
                free     = 1'b1;
                free_idx = TW'(i);
            end
        end
    end

    assign hit_owner = bind_owner_reg[hit_idx];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg        <= s_axis_tuser[0];
            key_reg        <= in_key;
            key_bad_reg    <= (in_key == KEY_RSV_LO) || (in_key == KEY_RSV_HI);
            worker_bad_reg <= (32'(in_caller) >= 32'(NUM_WORKERS));
            caller_reg     <= WW'(in_caller);
            handle_reg     <= in_handle[SW-1:0];
            hit_reg        <= hit;
            hit_idx_reg    <= hit_idx;
            owner_reg      <= hit_owner;
            free_reg       <= free;
            free_idx_reg   <= free_idx;
        end
    end

    // decision in the worker state cycle
    logic                out_free;
    logic                out_load;
    logic [HW-1:0]       cur_head;
    logic [CW-1:0]       cur_count;
    logic [CW:0]         slot_sum;
    logic [HW-1:0]       slot;
    logic [HW-1:0]       head_inc;
    logic [FAW-1:0]      fifo_addr;
    status_t             dec_status;
    logic [WW-1:0]       dec_owner;
    logic                dec_owner_set;
    logic                pop_data;
    logic                push_q;
    logic                do_bind;
    logic                do_release;
    logic                meta_go;
    logic                meta_we;
    meta_t               meta_wdata;
    logic                fifo_we;
    logic                fifo_re;
    logic [HANDLE_W-1:0] popped_ext;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cur_head  = meta_rd_valid_reg ? meta_rd_reg.head  : '0;
    assign cur_count = meta_rd_valid_reg ? meta_rd_reg.count : '0;
    assign slot_sum  = (CW + 1)'(cur_head) + (CW + 1)'(cur_count);
    assign slot      = (slot_sum >= (CW + 1)'(QUEUE_DEPTH))
                     ? HW'(slot_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);
    assign head_inc  = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

    always_comb
    begin
        dec_status    = STAT_ERROR;
        dec_owner     = '0;
        dec_owner_set = 1'b0;
        pop_data      = 1'b0;
        push_q        = 1'b0;
        do_bind       = 1'b0;
        do_release    = 1'b0;
        if (key_bad_reg)
        begin
            dec_status = STAT_ERROR;
        end
        else if (cmd_reg == CMD_PUSH)
        begin
            if (worker_bad_reg)
            begin
                dec_status = STAT_ERROR;
            end
            else if (hit_reg)
            begin
                dec_owner     = owner_reg;
                dec_owner_set = 1'b1;
                if (cur_count >= CW'(QUEUE_DEPTH))
                begin
                    dec_status = STAT_ERROR;
                end
                else
                begin
                    dec_status = STAT_QUEUED;
                    push_q     = 1'b1;
                end
            end
            else if (!free_reg)
            begin
                dec_status = STAT_TABLE_FULL;
            end
            else
            begin
                dec_status    = STAT_BOUND;
                dec_owner     = caller_reg;
                dec_owner_set = 1'b1;
                do_bind       = 1'b1;
            end
        end
        else
        begin
            if (!hit_reg)
            begin
                dec_status = STAT_NO_OWNER;
            end
            else if (cur_count == '0)
            begin
                dec_status = STAT_RELEASED;
                do_release = 1'b1;
            end
            else
            begin
                dec_status    = STAT_POPPED;
                dec_owner     = owner_reg;
                dec_owner_set = 1'b1;
                pop_data      = 1'b1;
            end
        end
    end

    // a pop with data moves on to the FIFO read; other results need the output slot
    assign meta_go = (state_reg == S_META) && (pop_data || out_free);
    assign meta_we = meta_go && (push_q || pop_data);
    assign fifo_we = meta_go && push_q;
    assign fifo_re = meta_go && pop_data;

    // a new result enters the output register
    assign out_load = (meta_go && !pop_data) || ((state_reg == S_DATA) && out_free);

    always_comb
    begin
        meta_wdata = meta_rd_reg;
        if (pop_data)
        begin
            meta_wdata.head  = head_inc;
            meta_wdata.count = cur_count - 1'b1;
        end
        else
        begin
            meta_wdata.head  = cur_head;
            meta_wdata.count = cur_count + 1'b1;
        end
    end

    assign fifo_addr = FAW'(owner_reg) * FAW'(QUEUE_DEPTH)
                     + FAW'(pop_data ? cur_head : slot);

    always_comb
    begin
        popped_ext = '0;
        popped_ext[SW-1:0] = fifo_rd_reg;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            meta_rd_reg       <= meta_mem[hit_owner];
            meta_rd_valid_reg <= meta_valid_reg[hit_owner];
        end
        if (meta_we)
        begin
            meta_mem[owner_reg] <= meta_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_addr] <= handle_reg;
        end
        if (fifo_re)
        begin
            fifo_rd_reg <= fifo_mem[fifo_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                meta_valid_reg[i] <= 1'b0;
            end
        end
        else if (meta_we)
        begin
            meta_valid_reg[owner_reg] <= 1'b1;
        end
    end

    // binding table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                bind_valid_reg[i] <= 1'b0;
            end
        end
        else if (meta_go && do_bind)
        begin
            bind_valid_reg[free_idx_reg] <= 1'b1;
        end
        else if (meta_go && do_release)
        begin
            bind_valid_reg[hit_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_go && do_bind)
        begin
            bind_key_reg[free_idx_reg]   <= key_reg;
            bind_owner_reg[free_idx_reg] <= caller_reg;
        end
    end

    // state machine and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_BOUND;
            out_handle_reg <= '0;
            out_owner_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_META;
                    end
                end
                S_META:
                begin
                    if (meta_go)
                    begin
                        if (pop_data)
                        begin
                            state_reg <= S_DATA;
                        end
                        else
                        begin
                            state_reg      <= S_IDLE;
                            out_status_reg <= dec_status;
                            out_handle_reg <= '0;
                            out_owner_reg  <= dec_owner_set ? WORKER_W'(dec_owner) : '0;
                        end
                    end
                end
                S_DATA:
                begin
                    if (out_free)
                    begin
                        state_reg      <= S_IDLE;
                        out_status_reg <= STAT_POPPED;
                        out_handle_reg <= popped_ext;
                        out_owner_reg  <= WORKER_W'(owner_reg);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - HANDLE_W - WORKER_W){1'b0}},
                            out_owner_reg, out_handle_reg};

    // checks
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("transfer accepted while an item is in flight");

    a_handle_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_POPPED)) |-> (m_axis_tdata[31:0] == '0))
        else $error("nonzero handle on a result that is not a pop");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        meta_we |-> (meta_wdata.count <= CW'(QUEUE_DEPTH)))
        else $error("FIFO count written beyond queue depth");

    a_data_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> $past(fifo_re) || $past(state_reg == S_DATA))
        else $error("FIFO result state entered without a read");

endmodule
`default_nettype wire
